// ----- hw/rtl/dtshp_pkg.sv -----
// Package for the DTS core frame header parser.
// Holds sync words, error codes, the result record and the rate lookup tables.
// No dependencies.
package dtshp_pkg;

   localparam int unsigned REQ_DATA_W = 96;
   localparam int unsigned RSP_DATA_W = 88;

   localparam logic [31:0] SYNC_14LE = 32'hff1f00e8;
   localparam logic [31:0] SYNC_14BE = 32'h1fffe800;
   localparam logic [31:0] SYNC_16LE = 32'hfe7f0180;
   localparam logic [31:0] SYNC_16BE = 32'h7ffe8001;

   localparam logic [7:0] FTYPE_MASK = 8'hf0;
   localparam logic [7:0] FTYPE_BYTE = 8'h07;

   localparam logic [14:0] FRAME_MAX = 15'd8192;
   localparam logic [14:0] FRAME_MIN = 15'd96;

   typedef enum logic [1:0] {
      LAYOUT_14LE = 2'd0,
      LAYOUT_14BE = 2'd1,
      LAYOUT_16LE = 2'd2,
      LAYOUT_16BE = 2'd3
   } dtshp_layout_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_NO_SYNC   = 3'd1,
      ERR_FRAME_TYP = 3'd2,
      ERR_TERMINATE = 3'd3,
      ERR_SIZE      = 3'd4,
      ERR_BLOCKS    = 3'd5
   } dtshp_err_type;

   typedef struct packed {
      logic [17:0]     sample_hz;
      logic [21:0]     bits_per_second;
      logic [3:0]      freq_index;
      logic [4:0]      rate_index;
      logic [5:0]      channel_mode;
      logic [7:0]      block_count;
      logic [13:0]     frame_bytes;
      dtshp_layout_type stream_layout;
      dtshp_err_type   error_kind;
      logic            header_ok;
   } dtshp_result_type;

   function automatic logic [21:0] rate_bps(input logic [4:0] idx);
      logic [21:0] bps;
      case (idx)
         5'd0:    bps = 22'd32000;
         5'd1:    bps = 22'd56000;
         5'd2:    bps = 22'd64000;
         5'd3:    bps = 22'd96000;
         5'd4:    bps = 22'd112000;
         5'd5:    bps = 22'd128000;
         5'd6:    bps = 22'd192000;
         5'd7:    bps = 22'd224000;
         5'd8:    bps = 22'd256000;
         5'd9:    bps = 22'd320000;
         5'd10:   bps = 22'd384000;
         5'd11:   bps = 22'd448000;
         5'd12:   bps = 22'd512000;
         5'd13:   bps = 22'd576000;
         5'd14:   bps = 22'd640000;
         5'd15:   bps = 22'd768000;
         5'd16:   bps = 22'd896000;
         5'd17:   bps = 22'd1024000;
         5'd18:   bps = 22'd1152000;
         5'd19:   bps = 22'd1280000;
         5'd20:   bps = 22'd1344000;
         5'd21:   bps = 22'd1408000;
         5'd22:   bps = 22'd1411200;
         5'd23:   bps = 22'd1472000;
         5'd24:   bps = 22'd1536000;
         5'd25:   bps = 22'd1920000;
         5'd26:   bps = 22'd2048000;
         5'd27:   bps = 22'd3072000;
         5'd28:   bps = 22'd3840000;
         5'd29:   bps = 22'd4096000;
         default: bps = 22'd0;
      endcase
      return bps;
   endfunction

   function automatic logic [17:0] freq_hz(input logic [3:0] idx);
      logic [17:0] hz;
      case (idx)
         4'd1:    hz = 18'd8000;
         4'd2:    hz = 18'd16000;
         4'd3:    hz = 18'd32000;
         4'd4:    hz = 18'd64000;
         4'd5:    hz = 18'd128000;
         4'd6:    hz = 18'd11025;
         4'd7:    hz = 18'd22050;
         4'd8:    hz = 18'd44100;
         4'd9:    hz = 18'd88200;
         4'd10:   hz = 18'd176400;
         4'd11:   hz = 18'd12000;
         4'd12:   hz = 18'd24000;
         4'd13:   hz = 18'd48000;
         4'd14:   hz = 18'd96000;
         4'd15:   hz = 18'd192000;
         default: hz = 18'd0;
      endcase
      return hz;
   endfunction

endpackage

// ----- hw/rtl/dtshp_frame_size.sv -----
// 14-bit mode frame size conversion: bytes = floor(raw * 8 / 14) * 2.
// Divide by 7 through a reciprocal multiply and one correction step.
// No package dependencies.
module dtshp_frame_size (
   input  logic [14:0] raw_size,
   output logic [14:0] frame_bytes
);

   // floor(2^16 / 7); estimate is low by at most one for n <= 2^16
   localparam logic [13:0] RECIP7 = 14'd9362;

   logic [16:0] num;
   logic [29:0] prod;
   logic [13:0] q_est;
   logic [16:0] seven_q;
   logic [16:0] rem;
   logic [13:0] q_fix;

   assign num     = {raw_size, 2'b00};
   assign prod    = 30'(num) * 30'(RECIP7);
   assign q_est   = prod[29:16];
   assign seven_q = {q_est, 3'b000} - {3'b000, q_est};
   assign rem     = num - seven_q;
   assign q_fix   = (rem >= 17'd7) ? q_est + 14'd1 : q_est;

   assign frame_bytes = {q_fix, 1'b0};

endmodule

// ----- hw/rtl/dtshp_decode.sv -----
// Header decode: sync layout match, frame-type and termination checks,
// field extraction, range checks and rate table lookup.
// Depends on dtshp_pkg and dtshp_frame_size.
module dtshp_decode (
   input  logic [63:0]                head_bytes_a,
   input  logic [31:0]                head_bytes_b,
   output dtshp_pkg::dtshp_result_type result
);
   import dtshp_pkg::*;

   logic [7:0]  hb [12];
   logic        sync_ok;
   dtshp_layout_type layout;
   logic        le;
   logic        wide;
   logic [7:0]  s4, s5, s6, s7, s8, s9, s10;
   logic        ftype_bad;
   logic        term_frame;
   logic [14:0] narrow_raw;
   logic [14:0] narrow_bytes;
   logic [14:0] wide_bytes;
   logic [14:0] fsize;
   logic [7:0]  nblks;
   logic [5:0]  amode;
   logic [3:0]  sfreq;
   logic [4:0]  rate;
   logic        size_bad;
   logic        blocks_bad;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         hb[i] = head_bytes_a[63 - 8*i -: 8];
      end
      for (int i = 0; i < 4; i++) begin
         hb[8 + i] = head_bytes_b[31 - 8*i -: 8];
      end
   end

   always_comb begin
      sync_ok = 1'b1;
      layout  = LAYOUT_14LE;
      if (head_bytes_a[63:32] == SYNC_14LE) begin
         layout = LAYOUT_14LE;
      end else if (head_bytes_a[63:32] == SYNC_14BE) begin
         layout = LAYOUT_14BE;
      end else if (head_bytes_a[63:32] == SYNC_16LE) begin
         layout = LAYOUT_16LE;
      end else if (head_bytes_a[63:32] == SYNC_16BE) begin
         layout = LAYOUT_16BE;
      end else begin
         sync_ok = 1'b0;
      end
   end

   assign le   = (layout == LAYOUT_14LE) || (layout == LAYOUT_16LE);
   assign wide = (layout == LAYOUT_16LE) || (layout == LAYOUT_16BE);

   // little-endian layouts swap bytes within each 16-bit word
   assign s4  = le ? hb[5]  : hb[4];
   assign s5  = le ? hb[4]  : hb[5];
   assign s6  = le ? hb[7]  : hb[6];
   assign s7  = le ? hb[6]  : hb[7];
   assign s8  = le ? hb[9]  : hb[8];
   assign s9  = le ? hb[8]  : hb[9];
   assign s10 = le ? hb[11] : hb[10];

   assign ftype_bad =
      ((layout == LAYOUT_14LE) &&
       (((hb[4] & FTYPE_MASK) != FTYPE_MASK) || (hb[5] != FTYPE_BYTE))) ||
      ((layout == LAYOUT_14BE) &&
       ((hb[4] != FTYPE_BYTE) || ((hb[5] & FTYPE_MASK) != FTYPE_MASK)));

   assign term_frame = wide && !s4[7];

   assign narrow_raw = {1'b0, s6[1:0], s7, s8[5:2]} + 15'd1;
   assign wide_bytes = {1'b0, s5[1:0], s6, s7[7:4]} + 15'd1;

   dtshp_frame_size u_frame_size (
      .raw_size    (narrow_raw),
      .frame_bytes (narrow_bytes)
   );

   always_comb begin
      if (wide) begin
         fsize = wide_bytes;
         nblks = {1'b0, s4[0], s5[7:2]} + 8'd1;
         amode = {s7[3:0], s8[7:6]};
         sfreq = s8[5:2];
         rate  = {s8[1:0], s9[7:5]};
      end else begin
         fsize = narrow_bytes;
         nblks = {1'b0, s5[2:0], s6[5:2]} + 8'd1;
         amode = {s8[1:0], s9[7:4]};
         sfreq = s9[3:0];
         rate  = s10[5:1];
      end
   end

   assign size_bad   = (fsize > FRAME_MAX) || (fsize < FRAME_MIN);
   assign blocks_bad = !((nblks == 8'd8) || (nblks == 8'd16) || (nblks == 8'd32) ||
                         (nblks == 8'd64) || (nblks == 8'd128));

   always_comb begin
      result               = '0;
      result.stream_layout = layout;
      if (!sync_ok) begin
         result.error_kind    = ERR_NO_SYNC;
         result.stream_layout = LAYOUT_14LE;
      end else if (ftype_bad) begin
         result.error_kind = ERR_FRAME_TYP;
      end else if (term_frame) begin
         result.error_kind = ERR_TERMINATE;
      end else if (size_bad) begin
         result.error_kind = ERR_SIZE;
      end else if (blocks_bad) begin
         result.error_kind = ERR_BLOCKS;
      end else begin
         result.error_kind      = ERR_NONE;
         result.header_ok       = 1'b1;
         result.frame_bytes     = fsize[13:0];
         result.block_count     = nblks;
         result.channel_mode    = amode;
         result.rate_index      = rate;
         result.freq_index      = sfreq;
         result.bits_per_second = rate_bps(rate);
         result.sample_hz       = freq_hz(sfreq);
      end
   end

endmodule

// ----- hw/rtl/dts_core_header_parser.sv -----
// DTS core frame header parser, top level.
// A req is captured in the input register; its decoded result is registered to rsp.
// Throughput: one header per cycle; the input register and the result register
// form a two-stage pipeline, and req_tready only drops when both hold data and
// rsp_tready is low. Synchronous active-high reset empties both stages.
// Depends on dtshp_pkg and dtshp_decode.
module dts_core_header_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [63:0] head_bytes_a, [95:64] head_bytes_b
   input  logic [dtshp_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] header_ok, [3:1] error_kind, [5:4] stream_layout, [19:6] frame_bytes,
   // [27:20] block_count, [33:28] channel_mode, [38:34] rate_index,
   // [42:39] freq_index, [64:43] bits_per_second, [82:65] sample_hz, [87:83] zero
   output logic [dtshp_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import dtshp_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  out_ready;
   logic                  in_ready;
   dtshp_result_type      result;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign in_ready   = !in_valid_ff || out_ready;
   assign req_tready = in_ready;

   dtshp_decode u_decode (
      .head_bytes_a (in_data_ff[63:0]),
      .head_bytes_b (in_data_ff[95:64]),
      .result       (result)
   );

   always_comb begin
      in_valid_in  = in_ready  ? req_tvalid  : in_valid_ff;
      rsp_valid_in = out_ready ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_tvalid) begin
         in_data_ff <= req_tdata;
      end
      if (out_ready && in_valid_ff) begin
         rsp_data_ff <= {5'b00000,
                         result.sample_hz,
                         result.bits_per_second,
                         result.freq_index,
                         result.rate_index,
                         result.channel_mode,
                         result.block_count,
                         result.frame_bytes,
                         result.stream_layout,
                         result.error_kind,
                         result.header_ok};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hw/rtl/dtshp_checker.sv -----
// Port-level checks for the DTS core frame header parser, bound to the top level.
// Depends on dtshp_pkg and dts_core_header_parser.
module dtshp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [dtshp_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import dtshp_pkg::*;

   logic       ok_bit;
   logic [2:0] err_bits;
   logic [13:0] fbytes;
   logic [7:0] blocks;

   assign ok_bit   = rsp_tdata[0];
   assign err_bits = rsp_tdata[3:1];
   assign fbytes   = rsp_tdata[19:6];
   assign blocks   = rsp_tdata[27:20];

   // accept flag agrees with the error code
   a_ok_matches_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ok_bit == (err_bits == ERR_NONE)))
      else $error("header_ok disagrees with error_kind");

   // rejected headers carry nothing but error code and layout
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !ok_bit) |-> (rsp_tdata[RSP_DATA_W-1:6] == '0))
      else $error("rejected header carries nonzero fields");

   // accepted headers respect size and block count limits
   a_accept_ranges: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ok_bit) |->
         ((fbytes <= FRAME_MAX[13:0]) && (fbytes >= FRAME_MIN[13:0]) &&
          $onehot(blocks) && (blocks >= 8'd8)))
      else $error("accepted header out of range");

   // an empty result stage never blocks the input
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !rsp_tvalid) |-> req_tready)
      else $error("input stalled with empty result stage");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind dts_core_header_parser dtshp_checker u_dtshp_checker (.*);
